[rtl/mf3_pkg.sv]
// ============================================================================
// mf3_pkg - shared types, constants and compare helpers
// Pixel and window column types, register indexes and the small min, max and
// median selectors used by the 3x3 median filter.
// ============================================================================
`default_nettype none

package mf3_pkg;

    localparam int PIX_W         = 8;
    localparam int ROW_W         = 12;
    localparam int FW_W          = 11;
    localparam int FH_W          = 13;
    localparam int CFG_W         = 13;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT    = 4096;
    localparam int MIN_SIZE      = 3;
    localparam int RST_WIDTH     = 512;
    localparam int RST_HEIGHT    = 512;

    typedef logic [PIX_W-1:0] pix_t;

    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    // One window column: its three pixels sorted, plus the raw middle-row pixel.
    typedef struct packed {
        pix_t lo;
        pix_t mi;
        pix_t hi;
        pix_t ctr;
    } col_t;

    function automatic pix_t max2(input pix_t a, input pix_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic pix_t min2(input pix_t a, input pix_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
        return max2(max2(a, b), c);
    endfunction

    function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
        return min2(min2(a, b), c);
    endfunction

    function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    function automatic col_t sort3(input pix_t top, input pix_t mid, input pix_t bot);
        col_t col;
        col.lo  = min3(top, mid, bot);
        col.mi  = med3(top, mid, bot);
        col.hi  = max3(top, mid, bot);
        col.ctr = mid;
        return col;
    endfunction

endpackage

`default_nettype wire

[rtl/mf3_line_ram.sv]
// ============================================================================
// mf3_line_ram - one row of pixel storage
// Single write port and one registered read port with read enable. A read
// and a write to the same address in one cycle return the old contents.
// ============================================================================
`default_nettype none

module mf3_line_ram
    import mf3_pkg::*;
#(
    parameter int  DEPTH = MAX_WIDTH_DEF,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire pix_t          wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output pix_t               rdata
);

    pix_t mem [DEPTH];
    pix_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/mf3_col_cell.sv]
// ============================================================================
// mf3_col_cell - one column of the 3x3 window
// Holds a sorted column and passes it to its left neighbour on every shift.
// ============================================================================
`default_nettype none

module mf3_col_cell
    import mf3_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic shift_en,
    input  wire col_t col_in,
    output col_t      col_out
);

    col_t col_reg;
    col_t col_next;

    assign col_next = shift_en ? col_in : col_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
        end else begin
            col_reg <= col_next;
        end
    end

    assign col_out = col_reg;

endmodule

`default_nettype wire

[rtl/mf3_median.sv]
// ============================================================================
// mf3_median - median of nine from three sorted columns
// First stage registers the largest low, the middle of the mids and the
// smallest high; the median of those three is the median of the window.
// ============================================================================
`default_nettype none

module mf3_median
    import mf3_pkg::*;
(
    input  wire logic aclk,
    input  wire logic en,
    input  wire col_t col_l,
    input  wire col_t col_c,
    input  wire col_t col_r,
    output pix_t      med
);

    pix_t lo_max_reg;
    pix_t mi_med_reg;
    pix_t hi_min_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            lo_max_reg <= max3(col_l.lo, col_c.lo, col_r.lo);
            mi_med_reg <= med3(col_l.mi, col_c.mi, col_r.mi);
            hi_min_reg <= min3(col_l.hi, col_c.hi, col_r.hi);
        end
    end

    assign med = med3(lo_max_reg, mi_med_reg, hi_min_reg);

endmodule

`default_nettype wire

[rtl/median_filter_3x3.sv]
// ============================================================================
// median_filter_3x3 - streaming 3x3 median filter for 8-bit grayscale
// Raster-order pixels in, median-filtered pixels out, borders passed through.
// ============================================================================
// The block takes one item per clock and gives at most one result per clock
// when the result side keeps m_ready high. A pixel item is accepted, reads the
// line buffers, shifts the window chain, goes through the two-stage median
// select and lands in the output register. In stream terms the results trail
// the pixels by one row plus one pixel, so after the last pixel of a frame the
// host sends flush items (s_flush high), each of which drains one pending
// result; a flush at any other time is swallowed silently. Every pipeline
// stage has its own valid flag and moves whenever the stage after it is empty
// or moving, so a waiting result stops new items only once the three stages
// behind the output register are all full. The throughput is set by the line
// buffers, which take one write and one read per port in each cycle, and by
// the window chain, which moves one column per pixel. The frame size is set
// through the write-only configuration port and is clamped to 3..MAX_WIDTH by
// 3..4096; write it only while the block is idle. The line buffers are not
// cleared at reset and need no start-up pass.
// ============================================================================
`default_nettype none

module median_filter_3x3
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    // input items
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [PIX_W-1:0] s_pixel_in,
    input  wire logic             s_flush,
    // result items
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [PIX_W-1:0]      m_pixel_out,
    output logic                  m_frame_last,
    // configuration writes
    input  wire logic             cfg_we,
    input  wire logic             cfg_index,
    input  wire logic [CFG_W-1:0] cfg_wdata
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int RST_W_EFF = (RST_WIDTH < MAX_WIDTH) ? RST_WIDTH : MAX_WIDTH;

    // What an item turns into when it reaches the output register.
    typedef enum logic [2:0] {
        RES_NONE,
        RES_EDGE,
        RES_CENTRE,
        RES_MEDIAN,
        RES_FLUSH_L1,
        RES_FLUSH_L2
    } res_kind_t;

    // Control carried with an item while its line buffer reads are in flight.
    typedef struct packed {
        res_kind_t        kind;
        logic             last;
        logic             wr_line;
        pix_t             pix;
        logic [COL_W-1:0] addr;
        logic             fwd_a;
        logic             fwd_b;
    } s1_t;

    // ------------------------------------------------------------------
    // Frame size registers. The stored values are the clamped size minus
    // one, so every end-of-row and end-of-frame test is a plain compare.
    // ------------------------------------------------------------------
    logic [COL_W-1:0] w_m1_reg, w_m1_next;
    logic [ROW_W-1:0] h_m1_reg, h_m1_next;
    logic [FW_W-1:0]  cfg_w;
    logic [FH_W-1:0]  cfg_h;

    always_comb begin
        cfg_w     = cfg_wdata[FW_W-1:0];
        cfg_h     = cfg_wdata[FH_W-1:0];
        w_m1_next = w_m1_reg;
        h_m1_next = h_m1_reg;
        if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH: begin
                    if (32'(cfg_w) < MIN_SIZE) begin
                        w_m1_next = COL_W'(MIN_SIZE - 1);
                    end else if (32'(cfg_w) > MAX_WIDTH) begin
                        w_m1_next = COL_W'(MAX_WIDTH - 1);
                    end else begin
                        w_m1_next = COL_W'(cfg_w - FW_W'(1));
                    end
                end
                REG_FRAME_HEIGHT: begin
                    if (32'(cfg_h) < MIN_SIZE) begin
                        h_m1_next = ROW_W'(MIN_SIZE - 1);
                    end else if (32'(cfg_h) > MAX_HEIGHT) begin
                        h_m1_next = ROW_W'(MAX_HEIGHT - 1);
                    end else begin
                        h_m1_next = ROW_W'(cfg_h - FH_W'(1));
                    end
                end
                default: begin
                    w_m1_next = w_m1_reg;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline handshake. Each stage moves on when the next one is empty
    // or moving; the output register is the last stage.
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, m_valid_reg;
    logic ready_o, ready3, ready2, ready1;
    logic adv1, adv2, adv3;
    logic accept;

    assign ready_o = !m_valid_reg || m_ready;
    assign ready3  = !v3_reg || ready_o;
    assign ready2  = !v2_reg || ready3;
    assign ready1  = !v1_reg || ready2;
    assign adv3    = v3_reg && ready_o;
    assign adv2    = v2_reg && ready3;
    assign adv1    = v1_reg && ready2;
    assign s_ready = ready1;
    assign accept  = s_valid && ready1;

    // ------------------------------------------------------------------
    // Input side: raster position, output position and what the item
    // will produce, all settled at acceptance.
    // ------------------------------------------------------------------
    logic [ROW_W-1:0] in_row_reg, in_row_next, out_row_reg, out_row_next;
    logic [COL_W-1:0] in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [ROW_W-1:0] pos_row, adv_row, r_m1;
    logic [COL_W-1:0] pos_col, adv_col, c_m1;
    logic             at_start, emit, border, flush_ok, has_res, pos_last;
    logic [COL_W-1:0] rd_addr;
    logic             l2_wr;
    s1_t              s1_reg, s1_next;
    pix_t             l1_rdata, l2a_rdata, l2b_rdata;

    always_comb begin
        at_start = (in_row_reg == '0) && (in_col_reg == '0);
        // A new frame restarts the output position; a flush continues it.
        if (s_flush) begin
            pos_row = out_row_reg;
            pos_col = out_col_reg;
        end else if (at_start) begin
            pos_row = '0;
            pos_col = '0;
        end else begin
            pos_row = out_row_reg;
            pos_col = out_col_reg;
        end
        pos_last = (pos_row >= h_m1_reg) && (pos_col >= w_m1_reg);

        if (pos_col >= w_m1_reg) begin
            adv_col = '0;
            adv_row = (pos_row >= h_m1_reg) ? '0 : pos_row + ROW_W'(1);
        end else begin
            adv_col = pos_col + COL_W'(1);
            adv_row = pos_row;
        end

        if (in_col_reg >= w_m1_reg) begin
            in_col_next = '0;
            in_row_next = (in_row_reg >= h_m1_reg) ? '0 : in_row_reg + ROW_W'(1);
        end else begin
            in_col_next = in_col_reg + COL_W'(1);
            in_row_next = in_row_reg;
        end

        emit = (in_row_reg >= ROW_W'(2))
            || ((in_row_reg == ROW_W'(1)) && (in_col_reg != '0));
        r_m1 = in_row_reg - ROW_W'(1);
        c_m1 = in_col_reg - COL_W'(1);
        border = (r_m1 == '0) || (c_m1 == '0) || (r_m1 >= h_m1_reg)
              || (c_m1 >= w_m1_reg);
        flush_ok = at_start && !((out_row_reg == '0) && (out_col_reg == '0));

        if (s_flush) begin
            has_res = flush_ok;
            if (!flush_ok) begin
                s1_next.kind = RES_NONE;
            end else if (out_row_reg >= h_m1_reg) begin
                s1_next.kind = RES_FLUSH_L1;
            end else begin
                s1_next.kind = RES_FLUSH_L2;
            end
        end else begin
            has_res = emit;
            if (!emit) begin
                s1_next.kind = RES_NONE;
            end else if (in_col_reg == '0) begin
                // First column of a row: the previous row's right border pixel.
                s1_next.kind = RES_EDGE;
            end else if (border) begin
                s1_next.kind = RES_CENTRE;
            end else begin
                s1_next.kind = RES_MEDIAN;
            end
        end

        out_row_next = has_res ? adv_row : pos_row;
        out_col_next = has_res ? adv_col : pos_col;

        rd_addr = s_flush ? out_col_reg : in_col_reg;
        l2_wr   = adv1 && s1_reg.wr_line;

        s1_next.last    = pos_last;
        s1_next.wr_line = !s_flush;
        s1_next.pix     = s_pixel_in;
        s1_next.addr    = in_col_reg;
        // The upper line buffer is written as the item leaves stage 1; bypass that
        // write when it lands on an address being read in the same cycle.
        s1_next.fwd_a   = l2_wr && (s1_reg.addr == rd_addr);
        s1_next.fwd_b   = l2_wr && (s1_reg.addr == w_m1_reg);
    end

    // ------------------------------------------------------------------
    // Line buffers. The upper buffer is kept twice so that the current
    // column and the right border column can be read together.
    // ------------------------------------------------------------------
    mf3_line_ram #(
        .DEPTH (MAX_WIDTH)
    ) u_line_above (
        .aclk  (aclk),
        .we    (accept && !s_flush),
        .waddr (in_col_reg),
        .wdata (s_pixel_in),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (l1_rdata)
    );

    mf3_line_ram #(
        .DEPTH (MAX_WIDTH)
    ) u_line_two_above_a (
        .aclk  (aclk),
        .we    (l2_wr),
        .waddr (s1_reg.addr),
        .wdata (l1_rdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (l2a_rdata)
    );

    mf3_line_ram #(
        .DEPTH (MAX_WIDTH)
    ) u_line_two_above_b (
        .aclk  (aclk),
        .we    (l2_wr),
        .waddr (s1_reg.addr),
        .wdata (l1_rdata),
        .re    (accept),
        .raddr (w_m1_reg),
        .rdata (l2b_rdata)
    );

    // ------------------------------------------------------------------
    // Stage 1: read data is here. Build the new window column and pick
    // the pass-through value for edge and flush items.
    // ------------------------------------------------------------------
    pix_t      fwd_data_reg;
    pix_t      top_pix, edge_pix, val2_next;
    col_t      new_col;
    logic      shift_en;
    res_kind_t kind2_reg;
    logic      last2_reg;
    pix_t      val2_reg;

    always_comb begin
        top_pix  = s1_reg.fwd_a ? fwd_data_reg : l2a_rdata;
        edge_pix = s1_reg.fwd_b ? fwd_data_reg : l2b_rdata;
        new_col  = sort3(top_pix, l1_rdata, s1_reg.pix);
        shift_en = adv1 && s1_reg.wr_line;
        unique case (s1_reg.kind)
            RES_EDGE:     val2_next = edge_pix;
            RES_FLUSH_L1: val2_next = l1_rdata;
            RES_FLUSH_L2: val2_next = top_pix;
            default:      val2_next = l1_rdata;
        endcase
    end

    // ------------------------------------------------------------------
    // Window: three column cells in a chain, newest on the right.
    // ------------------------------------------------------------------
    col_t win_col [3];

    genvar gi;
    generate
        for (gi = 0; gi < 3; gi++) begin : g_win
            if (gi == 2) begin : g_head
                mf3_col_cell u_cell (
                    .aclk     (aclk),
                    .aresetn  (aresetn),
                    .shift_en (shift_en),
                    .col_in   (new_col),
                    .col_out  (win_col[gi])
                );
            end else begin : g_body
                mf3_col_cell u_cell (
                    .aclk     (aclk),
                    .aresetn  (aresetn),
                    .shift_en (shift_en),
                    .col_in   (win_col[gi+1]),
                    .col_out  (win_col[gi])
                );
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Stage 2 to 3: median select runs on the window left by this item.
    // ------------------------------------------------------------------
    pix_t med_pix;
    logic has3_reg, med3_sel_reg, last3_reg;
    pix_t val3_reg;
    pix_t m_pixel_reg;
    logic m_last_reg;

    mf3_median u_median (
        .aclk  (aclk),
        .en    (adv2),
        .col_l (win_col[0]),
        .col_c (win_col[1]),
        .col_r (win_col[2]),
        .med   (med_pix)
    );

    // ------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_m1_reg    <= COL_W'(RST_W_EFF - 1);
            h_m1_reg    <= ROW_W'(RST_HEIGHT - 1);
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            w_m1_reg <= w_m1_next;
            h_m1_reg <= h_m1_next;
            if (accept) begin
                out_row_reg <= out_row_next;
                out_col_reg <= out_col_next;
                if (!s_flush) begin
                    in_row_reg <= in_row_next;
                    in_col_reg <= in_col_next;
                end
            end
            if (accept) begin
                v1_reg <= 1'b1;
            end else if (adv1) begin
                v1_reg <= 1'b0;
            end
            if (adv1) begin
                v2_reg <= 1'b1;
            end else if (adv2) begin
                v2_reg <= 1'b0;
            end
            if (adv2) begin
                v3_reg <= 1'b1;
            end else if (adv3) begin
                v3_reg <= 1'b0;
            end
            if (adv3 && has3_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_reg       <= s1_next;
            fwd_data_reg <= l1_rdata;
        end
        if (adv1) begin
            kind2_reg <= s1_reg.kind;
            last2_reg <= s1_reg.last;
            val2_reg  <= val2_next;
        end
        if (adv2) begin
            has3_reg     <= (kind2_reg != RES_NONE);
            med3_sel_reg <= (kind2_reg == RES_MEDIAN);
            last3_reg    <= last2_reg;
            val3_reg     <= (kind2_reg == RES_CENTRE) ? win_col[1].ctr : val2_reg;
        end
        if (adv3 && has3_reg) begin
            m_pixel_reg <= med3_sel_reg ? med_pix : val3_reg;
            m_last_reg  <= last3_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_pixel_out  = m_pixel_reg;
    assign m_frame_last = m_last_reg;

endmodule

`default_nettype wire

[rtl/mf3_checker.sv]
// ============================================================================
// mf3_checker - port-level checks for the 3x3 median filter
// Watches the handshakes of the top level over time; bound to every instance.
// ============================================================================
`default_nettype none

module mf3_checker
    import mf3_pkg::*;
(
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             s_valid,
    input wire logic             s_ready,
    input wire logic             m_valid,
    input wire logic             m_ready,
    input wire logic [PIX_W-1:0] m_pixel_out,
    input wire logic             m_frame_last
);

    // A stalled result holds still.
    a_out_hold: assert property (@(posedge aclk)
        aresetn && m_valid && !m_ready |=>
            m_valid && $stable(m_pixel_out) && $stable(m_frame_last))
        else $error("result changed while stalled");

    // With the output free, the pipeline drains and the input side is open.
    a_in_open: assert property (@(posedge aclk)
        aresetn && (!m_valid || m_ready) |-> s_ready)
        else $error("input blocked although output side is free");

    // No result can appear straight out of reset.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid ##1 !m_valid ##1 !m_valid)
        else $error("result too soon after reset");

    // The last pixel of a frame is never followed directly by another last pixel.
    a_last_once: assert property (@(posedge aclk)
        aresetn && m_valid && m_ready && m_frame_last |=> !(m_valid && m_frame_last))
        else $error("two frame ends in a row");

    // While an item is offered the block always answers with a known ready.
    a_accept_known: assert property (@(posedge aclk)
        aresetn && s_valid |-> !$isunknown(s_ready))
        else $error("input handshake unknown");

endmodule

bind median_filter_3x3 mf3_checker u_mf3_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_pixel_out  (m_pixel_out),
    .m_frame_last (m_frame_last)
);

`default_nettype wire
